/* rtl/tdpt_pkg.sv */
// Shared types for the trial-division prime test: controller states, commands and status.
`default_nettype none

package tdpt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL
  } tdpt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic next_div;
    logic finish;
    logic verdict;
  } tdpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lt_two;
    logic sq_gt;
    logic last_bit;
    logic rem_zero;
  } tdpt_sts_t;

  localparam int unsigned FIRST_DIVISOR = 2;
  localparam int unsigned FIRST_SQUARE  = 4;

endpackage

`default_nettype wire

/* rtl/tdpt_ctrl.sv */
// Controller state machine that sequences the bound check and each remainder computation.
`default_nettype none

module tdpt_ctrl
  import tdpt_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  wire tdpt_sts_t sts_i,
  output tdpt_cmd_t  cmd_o,
  output logic       busy_o
);

  tdpt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (sts_i.lt_two) begin
          cmd_o.finish  = 1'b1;
          cmd_o.verdict = 1'b0;
          state_d       = ST_IDLE;
        end else if (sts_i.sq_gt) begin
          cmd_o.finish  = 1'b1;
          cmd_o.verdict = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.last_bit) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.rem_zero) begin
          cmd_o.finish  = 1'b1;
          cmd_o.verdict = 1'b0;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/tdpt_dp.sv */
// Datapath: candidate, divisor and running square, bit-serial remainder unit and result register.
`default_nettype none

module tdpt_dp
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 36
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire [VALUE_BITS-1:0]  candidate_i,
  input  wire tdpt_cmd_t        cmd_i,
  output tdpt_sts_t             sts_o,
  output logic                  done_o,
  output logic                  is_prime_o
);

  localparam int unsigned HALF_BITS = (VALUE_BITS + 1) / 2;
  localparam int unsigned DIV_BITS  = HALF_BITS + 1;
  localparam int unsigned SQ_BITS   = VALUE_BITS + 2;
  localparam int unsigned CNT_BITS  = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] cand_q, cand_d;
  logic [VALUE_BITS-1:0] sh_q, sh_d;
  logic [DIV_BITS-1:0]   div_q, div_d;
  logic [SQ_BITS-1:0]    sq_q, sq_d;
  logic [DIV_BITS-1:0]   rem_q, rem_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  done_q, prime_q, prime_d;

  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     trial_sub;
  logic                  trial_ge;

  assign trial     = {rem_q, sh_q[VALUE_BITS-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign trial_ge  = (trial >= {1'b0, div_q});

  always_comb begin
    cand_d  = cand_q;
    sh_d    = sh_q;
    div_d   = div_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    prime_d = prime_q;
    if (cmd_i.load) begin
      cand_d = candidate_i;
      div_d  = DIV_BITS'(FIRST_DIVISOR);
      sq_d   = SQ_BITS'(FIRST_SQUARE);
    end
    if (cmd_i.div_init) begin
      sh_d  = cand_q;
      rem_d = '0;
      cnt_d = CNT_BITS'(VALUE_BITS);
    end
    if (cmd_i.div_step) begin
      sh_d  = {sh_q[VALUE_BITS-2:0], 1'b0};
      rem_d = trial_ge ? trial_sub[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      cnt_d = cnt_q - CNT_BITS'(1);
    end
    if (cmd_i.next_div) begin
      div_d = div_q + DIV_BITS'(1);
      sq_d  = sq_q + SQ_BITS'({div_q, 1'b1});
    end
    if (cmd_i.finish) begin
      prime_d = cmd_i.verdict;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    sh_q    <= sh_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    prime_q <= prime_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign sts_o.lt_two   = (cand_q[VALUE_BITS-1:1] == '0);
  assign sts_o.sq_gt    = (sq_q > {2'b00, cand_q});
  assign sts_o.last_bit = (cnt_q == CNT_BITS'(1));
  assign sts_o.rem_zero = (rem_q == '0);

  assign done_o     = done_q;
  assign is_prime_o = prime_q;

endmodule

`default_nettype wire

/* rtl/trial_division_prime_test.sv */
// Top level of the trial-division prime test: controller and datapath.
// A request is taken when start_i is high and busy_o is low; busy_o then stays high until
// the answer is ready. The answer appears on is_prime_o for one cycle with done_o high and
// cannot be held off, so it must be captured in that cycle; busy_o is already low then and
// the next request may be given at once. For each trial divisor d the controller first compares
// d*d (kept as a running square) against the candidate, then runs the one-bit-per-cycle
// restoring remainder unit over the candidate's bits, and then inspects the remainder. The
// number of divisors tried is at most about 2^(VALUE_BITS/2); candidates below four finish at
// the first bound check, with no division.
`default_nettype none

module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 36
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire [VALUE_BITS-1:0]  candidate_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic                  is_prime_o
);

  tdpt_cmd_t cmd;
  tdpt_sts_t sts;

  tdpt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  tdpt_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .candidate_i(candidate_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .done_o     (done_o),
    .is_prime_o (is_prime_o)
  );

endmodule

`default_nettype wire

/* rtl/tdpt_checker.sv */
// Port-level assertions for the trial-division prime test, bound to the top level.
`default_nettype none

module tdpt_checker #(
  parameter int unsigned VALUE_BITS = 36
) (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   start_i,
  input wire [VALUE_BITS-1:0]  candidate_i,
  input wire                   busy_o,
  input wire                   done_o,
  input wire                   is_prime_o
);

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after an accepted request");

  // The answer is shown only once the block is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done asserted while busy");

  // Every end of work delivers an answer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without an answer");

  // Each answer is a single-cycle strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done held for more than one cycle");

  // Zero and one are answered as not prime by the first bound check, with no division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (candidate_i[VALUE_BITS-1:1] == '0)) |-> ##2 (done_o && !is_prime_o))
    else $error("zero or one not reported as composite");

endmodule

bind trial_division_prime_test tdpt_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_tdpt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .candidate_i(candidate_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .is_prime_o (is_prime_o)
);

`default_nettype wire

/* tb/tb_trial_division_prime_test.sv */
// Self-checking testbench for the trial-division prime test, with directed and random requests.
module tb_trial_division_prime_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS       = 36;
  localparam int unsigned WATCHDOG_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES    = 100;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  typedef logic [VALUE_BITS-1:0] candidate_t;

  typedef struct {
    candidate_t value;
    logic       prime;
  } verdict_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start_i     = 1'b0;
  candidate_t candidate_i = '0;
  logic       busy_o;
  logic       done_o;
  logic       is_prime_o;

  verdict_t    verdicts_due[$];
  int unsigned requests_sent    = 0;
  int unsigned verdicts_checked = 0;
  int unsigned primes_seen      = 0;
  int unsigned failures         = 0;
  int unsigned idle_cycles      = 0;

  trial_division_prime_test #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .candidate_i(candidate_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .is_prime_o (is_prime_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic prime_verdict(input candidate_t value);
    longint unsigned n;
    longint unsigned d;
    n = value;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Candidates are mostly small or built with a small factor, so that each request stays short.
  function automatic candidate_t random_candidate();
    logic [63:0] wide;
    int unsigned pick;
    int unsigned factor;
    int unsigned root;
    pick = $urandom_range(99);
    if (pick < 30) return candidate_t'($urandom_range(1023));
    if (pick < 65) begin
      factor = $urandom_range(60, 2);
      wide = {$urandom, $urandom};
      wide = wide >> (64 - VALUE_BITS);
      wide = wide / factor;
      if (wide == 0) wide = 1;
      return candidate_t'(wide * factor);
    end
    if (pick < 80) begin
      root = $urandom_range(500, 2);
      wide = root * root + $urandom_range(2) - 1;
      return candidate_t'(wide);
    end
    return candidate_t'($urandom_range(32'd1 << 20, 1024));
  endfunction

  always @(posedge clk_i) begin
    verdict_t due;
    if (rst_ni && done_o) begin
      if (verdicts_due.size() == 0) begin
        failures++;
        if (failures <= SHOWN_MISMATCHES)
          $display("Unexpected result: is_prime=%0b with no request outstanding", is_prime_o);
      end else begin
        due = verdicts_due.pop_front();
        verdicts_checked++;
        if (due.prime) primes_seen++;
        if (is_prime_o !== due.prime) begin
          failures++;
          if (failures <= SHOWN_MISMATCHES)
            $display("Mismatch for candidate %0d: expected is_prime=%0b, got %0b",
                     due.value, due.prime, is_prime_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_candidate(input candidate_t value, input int unsigned idle_pct);
    int unsigned gap;
    verdict_t entry;
    gap = 0;
    if ($urandom_range(99) < idle_pct)
      gap = ($urandom_range(7) == 0) ? $urandom_range(300, 1) : $urandom_range(4, 1);
    repeat (gap) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    candidate_i <= value;
    do @(posedge clk_i); while (busy_o);
    entry.value = value;
    entry.prime = prime_verdict(value);
    verdicts_due.push_back(entry);
    requests_sent++;
  endtask

  task automatic wait_for_all_verdicts();
    start_i <= 1'b0;
    do @(negedge clk_i); while (verdicts_due.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic test_special_values();
    for (int unsigned v = 0; v <= 5; v++) send_candidate(candidate_t'(v), 0);
  endtask

  task automatic test_square_boundaries();
    send_candidate(candidate_t'(8), 0);
    send_candidate(candidate_t'(9), 0);
    send_candidate(candidate_t'(10), 0);
    send_candidate(candidate_t'(24), 0);
    send_candidate(candidate_t'(25), 0);
    send_candidate(candidate_t'(26), 0);
    send_candidate(candidate_t'(49), 0);
    send_candidate(candidate_t'(121), 0);
    send_candidate(candidate_t'(961), 0);
    send_candidate(candidate_t'(65521), 0);
    send_candidate(candidate_t'(1048573), 0);
  endtask

  task automatic test_width_extremes();
    send_candidate('1, 0);
    send_candidate(candidate_t'(36'h800000000), 0);
    send_candidate(candidate_t'(36'hFFFFFFFFE), 0);
    send_candidate(candidate_t'(36'hAAAAAAAAA), 0);
    send_candidate(candidate_t'(36'h555555555), 0);
    send_candidate(candidate_t'(36'h800000001), 0);
  endtask

  task automatic test_random_requests(input int unsigned count, input int unsigned idle_pct);
    repeat (count) send_candidate(random_candidate(), idle_pct);
  endtask

  // Each request here is sent only once the block has answered every earlier one.
  task automatic test_drained_requests(input int unsigned count);
    repeat (count) begin
      send_candidate(random_candidate(), 56);
      wait_for_all_verdicts();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_values();
    test_square_boundaries();
    test_width_extremes();
    test_random_requests(30, 0);
    test_random_requests(30, 56);
    test_drained_requests(10);
    test_random_requests(30, 22);
    wait_for_all_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d answers, %0d of them prime.",
             requests_sent, verdicts_checked, primes_seen);
    $display("Covered zero to five, square boundaries, full-width patterns and random mixes.");
    if (failures == 0 && verdicts_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures, %0d answers missing", failures, verdicts_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tdpt_pkg.sv
rtl/tdpt_ctrl.sv
rtl/tdpt_dp.sv
rtl/trial_division_prime_test.sv
rtl/tdpt_checker.sv
tb/tb_trial_division_prime_test.sv
